>>> hdl/wah_pkg.sv
// Package with the constants, register indexes and state type of the amplitude histogram.
`default_nettype none
package wah_pkg;

  localparam int MAX_LEVELS_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COUNT_BITS      = 16;
  localparam int LEVEL_REG_BITS  = 7;
  localparam int WINDOW_BITS     = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_LEVELS     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SAMPLES = 2'd1;

  localparam logic [LEVEL_REG_BITS-1:0] LEVELS_RESET = 7'd16;
  localparam logic [WINDOW_BITS-1:0]    WINDOW_RESET = 16'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FLUSH,
    ST_SCAN,
    ST_LOAD
  } wah_state_t;

endpackage
`default_nettype wire

>>> hdl/windowed_amplitude_histogram.sv
// Top level of the windowed amplitude histogram: bin counter memory, window control and report.
//
// Samples are taken one per cycle while a window is open: each one reads its bin count from
// a single-port-read, single-port-write memory, and the incremented count is written back in
// the next cycle, with forwarding when consecutive samples hit the same bin. The sample that
// completes a window is followed by a stall: a flush state retires the last increment, a sweep
// clears every memory entry, and each bin in use after clamping is read in its scan step and
// handed to the output register in a load step of its own, which waits while the output side
// stalls. After reset the input stalls while the memory is cleared; configuration writes are
// taken at any time.
`default_nettype none
module windowed_amplitude_histogram #(
  parameter int MAX_LEVELS  = wah_pkg::MAX_LEVELS_DEF,
  parameter int SAMPLE_BITS = wah_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [$clog2(MAX_LEVELS)-1:0]      bin_index,
  output      logic [wah_pkg::COUNT_BITS-1:0]     bin_count,
  output      logic                               last_bin,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [wah_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [wah_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IW  = $clog2(MAX_LEVELS);
  localparam int LVW = $clog2(MAX_LEVELS + 1);
  localparam int LCW = (LVW > wah_pkg::LEVEL_REG_BITS) ? LVW : wah_pkg::LEVEL_REG_BITS;
  localparam int PW  = LVW + SAMPLE_BITS;
  localparam int CB  = wah_pkg::COUNT_BITS;
  localparam logic [IW-1:0] LAST_ENTRY = IW'(MAX_LEVELS - 1);
  localparam logic [CB-1:0] COUNT_MAX  = {CB{1'b1}};

  logic [wah_pkg::LEVEL_REG_BITS-1:0] bin_levels;
  logic [wah_pkg::WINDOW_BITS-1:0]    window_samples;
  logic [wah_pkg::WINDOW_BITS-1:0]    samples_in_window;

  wah_pkg::wah_state_t state, state_next;
  logic [IW-1:0] sweep;

  logic [CB-1:0] mem [MAX_LEVELS];
  logic [CB-1:0] rd_data;
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  logic [CB-1:0] mem_wdata;

  logic          b_valid;
  logic [IW-1:0] b_addr;
  logic          wb_valid;
  logic [IW-1:0] wb_addr;
  logic [CB-1:0] wb_data;
  logic [CB-1:0] cur_count, inc_count;

  logic in_accept, out_free, scan_report, window_done;
  logic [LCW-1:0] lv_ext, lv_clamped;
  logic [LVW-1:0] lv, lv_m1;
  logic [SAMPLE_BITS-1:0] offset;
  logic [PW-1:0] product;
  logic [IW-1:0] bin;
  logic [wah_pkg::WINDOW_BITS-1:0] win, cnt_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_levels     <= wah_pkg::LEVELS_RESET;
      window_samples <= wah_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wah_pkg::REG_BIN_LEVELS:     bin_levels <= cfg_data[wah_pkg::LEVEL_REG_BITS-1:0];
        wah_pkg::REG_WINDOW_SAMPLES: window_samples <= cfg_data[wah_pkg::WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lv_ext = LCW'(bin_levels);
    if (lv_ext < LCW'(2)) begin
      lv_clamped = LCW'(2);
    end else if (lv_ext > LCW'(MAX_LEVELS)) begin
      lv_clamped = LCW'(MAX_LEVELS);
    end else begin
      lv_clamped = lv_ext;
    end
    lv      = lv_clamped[LVW-1:0];
    lv_m1   = lv - LVW'(1);
    offset  = {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};
    product = PW'(lv_m1) * PW'(offset);
    bin     = product[SAMPLE_BITS +: IW];
    win     = (window_samples == '0) ? wah_pkg::WINDOW_BITS'(1) : window_samples;
    cnt_inc = samples_in_window + wah_pkg::WINDOW_BITS'(1);
    window_done = (cnt_inc == '0) || (cnt_inc >= win);
  end

  assign in_stall    = (state != wah_pkg::ST_RUN);
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign scan_report = LVW'(sweep) < lv;

  always_comb begin
    state_next = state;
    case (state)
      wah_pkg::ST_CLEAR: begin
        if (sweep == LAST_ENTRY) state_next = wah_pkg::ST_RUN;
      end
      wah_pkg::ST_RUN: begin
        if (in_accept && window_done) state_next = wah_pkg::ST_FLUSH;
      end
      wah_pkg::ST_FLUSH: state_next = wah_pkg::ST_SCAN;
      wah_pkg::ST_SCAN: begin
        if (scan_report) begin
          state_next = wah_pkg::ST_LOAD;
        end else if (sweep == LAST_ENTRY) begin
          state_next = wah_pkg::ST_RUN;
        end
      end
      wah_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = (sweep == LAST_ENTRY) ? wah_pkg::ST_RUN : wah_pkg::ST_SCAN;
        end
      end
      default: state_next = wah_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cur_count = (wb_valid && (wb_addr == b_addr)) ? wb_data : rd_data;
    inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + CB'(1);
    mem_re    = 1'b0;
    mem_raddr = bin;
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = '0;
    if (b_valid) begin
      mem_we    = 1'b1;
      mem_waddr = b_addr;
      mem_wdata = inc_count;
    end
    case (state)
      wah_pkg::ST_CLEAR: mem_we = 1'b1;
      wah_pkg::ST_RUN:   mem_re = in_accept;
      wah_pkg::ST_SCAN: begin
        mem_we    = 1'b1;
        mem_re    = scan_report;
        mem_raddr = sweep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= wah_pkg::ST_CLEAR;
      sweep             <= '0;
      samples_in_window <= '0;
      b_valid           <= 1'b0;
      wb_valid          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state    <= state_next;
      b_valid  <= in_accept;
      wb_valid <= b_valid;
      if (in_accept) begin
        samples_in_window <= window_done ? '0 : cnt_inc;
      end
      case (state)
        wah_pkg::ST_CLEAR: sweep <= (sweep == LAST_ENTRY) ? '0 : sweep + IW'(1);
        wah_pkg::ST_FLUSH: sweep <= '0;
        wah_pkg::ST_SCAN: begin
          if (!scan_report) sweep <= (sweep == LAST_ENTRY) ? '0 : sweep + IW'(1);
        end
        wah_pkg::ST_LOAD: begin
          if (out_free) sweep <= (sweep == LAST_ENTRY) ? '0 : sweep + IW'(1);
        end
        default: ;
      endcase
      if (state == wah_pkg::ST_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_addr  <= bin;
    wb_addr <= b_addr;
    wb_data <= inc_count;
    if (state == wah_pkg::ST_LOAD && out_free) begin
      bin_index <= sweep;
      bin_count <= rd_data;
      last_bin  <= (LVW'(sweep) + LVW'(1)) == lv;
    end
  end

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (LVW'(bin) < lv_m1))
    else $error("sample mapped to a bin beyond the levels in use");

  a_no_rmw_in_sweep: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (state == wah_pkg::ST_RUN || state == wah_pkg::ST_FLUSH))
    else $error("count write-back overlaps the report sweep");

  a_beat_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == wah_pkg::ST_LOAD))
    else $error("result beat appeared outside the report");

  a_last_matches_levels: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_bin) |-> ((LVW'(bin_index) + LVW'(1)) == lv))
    else $error("last bin marker does not match the levels in use");

endmodule
`default_nettype wire
